/* rtl/core/rc4sc_pkg.sv */
// ----------------------------------------------------------------------------
// rc4sc_pkg
// shared types, constants and the microcode store of the stream cipher core
// ----------------------------------------------------------------------------
package rc4sc_pkg;

    localparam int KEY_MAX_BYTES_DEF = 16;
    localparam int PERM_DEPTH        = 256;
    localparam int BYTE_W            = 8;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [3:0]        upc_t;

    // microcode addresses
    localparam upc_t U_IDLE = 4'd0;
    localparam upc_t U_K0   = 4'd1;
    localparam upc_t U_K1   = 4'd2;
    localparam upc_t U_K2   = 4'd3;
    localparam upc_t U_K3   = 4'd4;
    localparam upc_t U_S0   = 4'd5;
    localparam upc_t U_L0   = 4'd6;
    localparam upc_t U_L1   = 4'd7;
    localparam upc_t U_L2   = 4'd8;
    localparam upc_t U_L3   = 4'd9;
    localparam upc_t U_S1   = 4'd10;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_I_INC,
        RD_J_SUM,
        RD_T,
        RD_I
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_I_Q,
        WR_J_SA
    } wr_sel_t;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_GOTO,
        JC_DISPATCH,
        JC_OUT,
        JC_LOOP
    } jump_t;

    typedef struct packed {
        rd_sel_t rd_sel;
        logic    key_rd;
        wr_sel_t wr_sel;
        logic    ld_i_inc;
        logic    ld_sa;
        logic    use_key;
        logic    ld_j;
        logic    ld_t;
        logic    clr;
        logic    pos_adv;
        logic    fin;
        logic    out_ld;
        logic    take;
        logic    key_wr;
        jump_t   jump;
        upc_t    target;
    } ctrl_t;

    typedef struct packed {
        logic i_last;
        logic out_busy;
    } stat_t;

    function automatic ctrl_t ucode_rom(upc_t upc);
        ctrl_t w;
        w        = ctrl_t'('0);
        w.rd_sel = RD_NONE;
        w.wr_sel = WR_NONE;
        w.jump   = JC_NEXT;
        w.target = U_IDLE;
        case (upc)
            U_IDLE:
            begin
                w.jump = JC_DISPATCH;
            end
            U_K0:
            begin
                w.rd_sel   = RD_I_INC;
                w.ld_i_inc = 1'b1;
            end
            U_K1:
            begin
                w.rd_sel = RD_J_SUM;
                w.ld_sa  = 1'b1;
                w.ld_j   = 1'b1;
            end
            U_K2:
            begin
                w.rd_sel = RD_T;
                w.wr_sel = WR_I_Q;
                w.ld_t   = 1'b1;
            end
            U_K3:
            begin
                w.wr_sel = WR_J_SA;
                w.out_ld = 1'b1;
                w.jump   = JC_OUT;
                w.target = U_IDLE;
            end
            U_S0:
            begin
                w.clr = 1'b1;
            end
            U_L0:
            begin
                w.rd_sel = RD_I;
                w.key_rd = 1'b1;
            end
            U_L1:
            begin
                w.rd_sel  = RD_J_SUM;
                w.ld_sa   = 1'b1;
                w.ld_j    = 1'b1;
                w.use_key = 1'b1;
            end
            U_L2:
            begin
                w.wr_sel = WR_I_Q;
            end
            U_L3:
            begin
                w.wr_sel   = WR_J_SA;
                w.ld_i_inc = 1'b1;
                w.pos_adv  = 1'b1;
                w.jump     = JC_LOOP;
                w.target   = U_L0;
            end
            U_S1:
            begin
                w.fin    = 1'b1;
                w.jump   = JC_GOTO;
                w.target = U_IDLE;
            end
            default:
            begin
                w.jump   = JC_GOTO;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/rc4sc_ram.sv */
// ----------------------------------------------------------------------------
// rc4sc_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module rc4sc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/rc4sc_useq.sv */
// ----------------------------------------------------------------------------
// rc4sc_useq
// microcode sequencer: step counter, control store and jump logic
// ----------------------------------------------------------------------------
module rc4sc_useq
    import rc4sc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    input  logic  mode,
    input  logic  key_last,
    input  stat_t stat,
    output logic  item_stall,
    output ctrl_t ctl
);

    upc_t  upc_reg;
    upc_t  upc_next;
    ctrl_t word;
    logic  idle;
    logic  take;

    assign idle       = (upc_reg == U_IDLE);
    assign take       = idle && item_valid;
    assign item_stall = !idle;
    assign word       = ucode_rom(upc_reg);

    always_comb
    begin
        ctl        = word;
        ctl.take   = take;
        ctl.key_wr = take && !mode;
    end

    always_comb
    begin
        case (word.jump)
            JC_NEXT:     upc_next = upc_reg + 4'd1;
            JC_GOTO:     upc_next = word.target;
            JC_DISPATCH:
            begin
                if (!item_valid)
                    upc_next = U_IDLE;
                else if (mode)
                    upc_next = U_K0;
                else if (key_last)
                    upc_next = U_S0;
                else
                    upc_next = U_IDLE;
            end
            JC_OUT:      upc_next = stat.out_busy ? upc_reg : word.target;
            JC_LOOP:     upc_next = stat.i_last ? (upc_reg + 4'd1) : word.target;
            default:     upc_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= U_IDLE;
        else
            upc_reg <= upc_next;
    end

    a_data_starts: assert property (@(posedge clk) disable iff (!rst_n)
        take && mode |=> upc_reg == U_K0)
        else $error("data beat did not start the keystream step");

    a_key_sched: assert property (@(posedge clk) disable iff (!rst_n)
        take && !mode && key_last |=> upc_reg == U_S0)
        else $error("final key beat did not start the key schedule");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg == U_K3 && stat.out_busy |=> upc_reg == U_K3)
        else $error("result overwritten while output held");

    a_loop_end: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg == U_L3 && stat.i_last |=> upc_reg == U_S1)
        else $error("key schedule loop did not end after last entry");

endmodule

/* rtl/core/rc4sc_dpath.sv */
// ----------------------------------------------------------------------------
// rc4sc_dpath
// datapath: permutation and key memories, indices, swap and result register
// ----------------------------------------------------------------------------
module rc4sc_dpath
    import rc4sc_pkg::*;
#(
    parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  ctrl_t ctl,
    input  byte_t byte_value,
    input  logic  result_stall,
    output stat_t stat,
    output logic  result_valid,
    output byte_t out_byte
);

    localparam int KIDX_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
    localparam int CNT_W  = $clog2(KEY_MAX_BYTES + 1);

    byte_t i_reg, i_next;
    byte_t j_reg, j_next;
    byte_t sa_reg;
    byte_t sj_reg;
    byte_t t_reg;
    byte_t data_reg;
    byte_t out_reg;
    logic  out_valid_reg, out_valid_next;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [KIDX_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]      pos_inc;
    logic [PERM_DEPTH-1:0] valid_reg, valid_next;
    logic                  rd_valid_reg;
    byte_t                 rd_addr_reg;

    byte_t ram_q;
    byte_t perm_q;
    byte_t key_q;
    byte_t kb;
    byte_t j_sum;
    byte_t t_sum;
    byte_t rd_addr;
    logic  rd_en;
    logic  wr_en;
    byte_t wr_addr;
    byte_t wr_data;
    byte_t ks;
    logic  out_busy;
    logic  out_load;
    logic  key_store_en;

    // unwritten entries read as their own index
    assign perm_q = rd_valid_reg ? ram_q : rd_addr_reg;
    assign kb     = (ctl.use_key && (count_reg != '0)) ? key_q : '0;
    assign j_sum  = byte_t'(j_reg + perm_q + kb);
    assign t_sum  = byte_t'(sa_reg + perm_q);

    always_comb
    begin
        case (ctl.rd_sel)
            RD_I_INC: rd_addr = byte_t'(i_reg + 8'd1);
            RD_J_SUM: rd_addr = j_sum;
            RD_T:     rd_addr = t_sum;
            RD_I:     rd_addr = i_reg;
            default:  rd_addr = i_reg;
        endcase
        rd_en = (ctl.rd_sel != RD_NONE);
    end

    always_comb
    begin
        case (ctl.wr_sel)
            WR_I_Q:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = perm_q;
            end
            WR_J_SA:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = sa_reg;
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_addr = i_reg;
                wr_data = perm_q;
            end
        endcase
    end

    rc4sc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    assign key_store_en = ctl.key_wr && (count_reg < CNT_W'(KEY_MAX_BYTES));

    rc4sc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (KEY_MAX_BYTES)
    ) u_key (
        .clk     (clk),
        .wr_en   (key_store_en),
        .wr_addr (count_reg[KIDX_W-1:0]),
        .wr_data (byte_value),
        .rd_en   (ctl.key_rd),
        .rd_addr (pos_reg),
        .rd_data (key_q)
    );

    // swap forwarding: the final read may hit an entry written in this step
    always_comb
    begin
        if (t_reg == j_reg)
            ks = sa_reg;
        else if (t_reg == i_reg)
            ks = sj_reg;
        else
            ks = perm_q;
    end

    assign out_busy = out_valid_reg && result_stall;
    assign out_load = ctl.out_ld && !out_busy;
    assign pos_inc  = CNT_W'(pos_reg) + CNT_W'(1);

    always_comb
    begin
        i_next         = i_reg;
        j_next         = j_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        valid_next     = valid_reg;
        out_valid_next = out_busy;
        if (ctl.ld_i_inc)
            i_next = byte_t'(i_reg + 8'd1);
        if (ctl.ld_j)
            j_next = j_sum;
        if (key_store_en)
            count_next = count_reg + CNT_W'(1);
        if (ctl.pos_adv)
            pos_next = (pos_inc >= count_reg) ? '0 : pos_inc[KIDX_W-1:0];
        if (wr_en)
            valid_next[wr_addr] = 1'b1;
        if (ctl.clr)
        begin
            i_next     = '0;
            j_next     = '0;
            pos_next   = '0;
            valid_next = '0;
        end
        if (ctl.fin)
        begin
            i_next     = '0;
            j_next     = '0;
            count_next = '0;
        end
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            j_reg         <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            i_reg         <= i_next;
            j_reg         <= j_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            rd_addr_reg  <= rd_addr;
        end
        if (ctl.ld_sa)
            sa_reg <= perm_q;
        if (ctl.ld_t)
        begin
            t_reg  <= t_sum;
            sj_reg <= perm_q;
        end
        if (ctl.take)
            data_reg <= byte_value;
        if (out_load)
            out_reg <= data_reg ^ ks;
    end

    assign stat.i_last   = (i_reg == byte_t'(PERM_DEPTH - 1));
    assign stat.out_busy = out_busy;
    assign result_valid  = out_valid_reg;
    assign out_byte      = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(KEY_MAX_BYTES))
        else $error("key count beyond key store size");

    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fin |=> i_reg == '0 && j_reg == '0 && count_reg == '0)
        else $error("indices or key count not cleared after schedule");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pos_adv && count_reg != '0 |=> CNT_W'(pos_reg) < count_reg)
        else $error("key position beyond stored key bytes");

endmodule

/* rtl/core/rc4_stream_cipher_core.sv */
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// byte-wide rc4 cipher driven by a microcoded sequencer
// ----------------------------------------------------------------------------
// Key bytes (mode 0) are taken and stored, up to KEY_MAX_BYTES of them. The
// beat marked key_last then runs the key schedule: a clearing step, the
// steps L0 to L3 for each of the 256 permutation entries and a final step,
// during which no beat is taken. A data byte (mode 1) runs through the steps
// K0 to K3 before the next beat is taken and gives one result beat; the
// permutation memory has one read and one write port, so the three reads and
// the two writes of a swap are spread over four steps. The result register
// lets the next beat in while a result waits to be taken. Before any key is
// loaded the permutation is the identity.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core
    import rc4sc_pkg::*;
#(
    parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       mode,
    input  logic [7:0] byte_value,
    input  logic       key_last,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte
);

    ctrl_t ctl;
    stat_t stat;

    rc4sc_useq u_useq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .mode       (mode),
        .key_last   (key_last),
        .stat       (stat),
        .item_stall (item_stall),
        .ctl        (ctl)
    );

    rc4sc_dpath #(
        .KEY_MAX_BYTES (KEY_MAX_BYTES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .byte_value   (byte_value),
        .result_stall (result_stall),
        .stat         (stat),
        .result_valid (result_valid),
        .out_byte     (out_byte)
    );

endmodule

/* test/tb_rc4_stream_cipher_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc4_stream_cipher_core
// self-checking bench for the byte-wide rc4 cipher core
// ----------------------------------------------------------------------------
// Key and data beats are queued by an initial block and sent by a clocked
// driver with random gaps. Each accepted beat updates a local rc4 model
// (permutation, key store, generator indices), which queues the output byte
// due for every data beat. A clocked monitor applies random stall on the
// result side and compares each result beat against the oldest byte due.
// The directed part covers data before any key, a one-byte key, a key longer
// than the store with the final byte dropped, key_last on data beats and the
// extreme byte values. The random part mixes keys of random length with runs
// of data beats.
// ----------------------------------------------------------------------------
module tb_rc4_stream_cipher_core;
    import rc4sc_pkg::*;

    localparam int KEY_BYTES = KEY_MAX_BYTES_DEF;
    localparam int N_BEATS   = 800;
    localparam int TAIL      = 1100;

    typedef struct {
        logic  mode;
        byte_t value;
        logic  last;
        logic  hold;
    } beat_t;

    logic  clk          = 1'b0;
    logic  rst_n        = 1'b0;
    logic  item_valid   = 1'b0;
    logic  item_stall;
    logic  mode         = 1'b0;
    byte_t byte_value   = '0;
    logic  key_last     = 1'b0;
    logic  result_valid;
    logic  result_stall = 1'b0;
    byte_t out_byte;

    beat_t beats_to_send[$];
    byte_t out_bytes_due[$];
    int    mismatch_cnt = 0;

    // local rc4 state
    byte_t sbox [PERM_DEPTH];
    byte_t key_mem [KEY_BYTES];
    int    key_len;
    byte_t gen_i;
    byte_t gen_j;

    rc4_stream_cipher_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .byte_value   (byte_value),
        .key_last     (key_last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    function automatic void swap_sbox(byte_t a, byte_t b);
        byte_t t;
        t       = sbox[a];
        sbox[a] = sbox[b];
        sbox[b] = t;
    endfunction

    function automatic void rc4_key_schedule();
        byte_t j;
        byte_t kb;
        int    pos;
        for (int n = 0; n < PERM_DEPTH; n++)
            sbox[n] = byte_t'(n);
        j   = '0;
        pos = 0;
        for (int n = 0; n < PERM_DEPTH; n++)
        begin
            kb = (key_len == 0) ? byte_t'(0) : key_mem[pos];
            j  = j + sbox[n] + kb;
            swap_sbox(byte_t'(n), j);
            pos++;
            if (pos >= key_len)
                pos = 0;
        end
        gen_i   = '0;
        gen_j   = '0;
        key_len = 0;
    endfunction

    function automatic byte_t rc4_keystream_byte();
        byte_t t;
        gen_i = gen_i + 8'd1;
        gen_j = gen_j + sbox[gen_i];
        swap_sbox(gen_i, gen_j);
        t = sbox[gen_i] + sbox[gen_j];
        return sbox[t];
    endfunction

    function automatic void rc4_absorb_beat(logic m, byte_t v, logic last);
        if (m == 1'b0)
        begin
            if (key_len < KEY_BYTES)
            begin
                key_mem[key_len] = v;
                key_len++;
            end
            if (last)
                rc4_key_schedule();
        end
        else
        begin
            out_bytes_due.push_back(v ^ rc4_keystream_byte());
        end
    endfunction

    // mostly short gaps, a few long ones, none in a calm phase
    function automatic int rand_gap(logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_beat(logic m, byte_t v, logic last, logic hold);
        beat_t b;
        b.mode  = m;
        b.value = v;
        b.last  = last;
        b.hold  = hold;
        beats_to_send.push_back(b);
    endtask

    task automatic queue_random_key(int len, logic hold);
        for (int k = 0; k < len; k++)
            queue_beat(1'b0, byte_t'($urandom_range(0, 255)), k == len - 1,
                       hold && k == 0);
    endtask

    // driver
    int   send_gap  = 0;
    int   in_phase  = 0;
    logic in_calm   = 1'b0;

    always @(posedge clk)
    begin : drive_proc
        beat_t b;
        logic  nv;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            nv = item_valid;
            if (item_valid && !item_stall)
            begin
                rc4_absorb_beat(mode, byte_value, key_last);
                nv       = 1'b0;
                send_gap = rand_gap(in_calm);
            end
            if (in_phase == 0)
            begin
                in_calm  = ($urandom_range(0, 3) == 0);
                in_phase = $urandom_range(50, 400);
            end
            else
            begin
                in_phase--;
            end
            if (!nv)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (beats_to_send.size() != 0 &&
                         !(beats_to_send[0].hold && out_bytes_due.size() != 0))
                begin
                    b = beats_to_send.pop_front();
                    mode       <= b.mode;
                    byte_value <= b.value;
                    key_last   <= b.last;
                    nv = 1'b1;
                end
            end
            item_valid <= nv;
        end
    end

    // monitor and result-side stall
    int   stall_left = 0;
    int   out_phase  = 0;
    logic out_calm   = 1'b0;

    always @(posedge clk)
    begin : watch_proc
        byte_t due;
        logic  rs;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (out_bytes_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result beat, out_byte=%02h",
                                              out_byte));
                end
                else
                begin
                    due = out_bytes_due.pop_front();
                    if (out_byte !== due)
                        report_mismatch($sformatf("out_byte=%02h, want %02h",
                                                  out_byte, due));
                end
            end
            if (out_phase == 0)
            begin
                out_calm  = ($urandom_range(0, 3) == 0);
                out_phase = $urandom_range(50, 400);
            end
            else
            begin
                out_phase--;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rs = 1'b1;
            end
            else
            begin
                rs = 1'b0;
                if (!out_calm && $urandom_range(0, 3) == 0)
                    stall_left = rand_gap(1'b0);
            end
            result_stall <= rs;
        end
    end

    // stimulus and end of run
    initial
    begin : stim_proc
        int n_beats;
        int len;
        for (int n = 0; n < PERM_DEPTH; n++)
            sbox[n] = byte_t'(n);
        for (int n = 0; n < KEY_BYTES; n++)
            key_mem[n] = '0;
        key_len = 0;
        gen_i   = '0;
        gen_j   = '0;

        // data on the identity permutation
        queue_beat(1'b1, 8'h00, 1'b0, 1'b0);
        queue_beat(1'b1, 8'hFF, 1'b0, 1'b0);
        // one-byte key, then key_last on data beats
        queue_beat(1'b0, 8'h00, 1'b1, 1'b1);
        queue_beat(1'b1, 8'hFF, 1'b1, 1'b0);
        queue_beat(1'b1, 8'h00, 1'b1, 1'b0);
        // key longer than the store, last byte dropped
        for (int k = 0; k < KEY_BYTES + 1; k++)
            queue_beat(1'b0, (k % 2 == 0) ? 8'hFF : 8'h00, k == KEY_BYTES, 1'b0);
        queue_beat(1'b1, 8'h5A, 1'b0, 1'b0);
        queue_beat(1'b1, 8'hFF, 1'b0, 1'b1);
        n_beats = beats_to_send.size();

        while (n_beats < N_BEATS)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(KEY_BYTES + 1, KEY_BYTES + 8);
                else
                    len = $urandom_range(1, KEY_BYTES);
                queue_random_key(len, $urandom_range(0, 9) == 0);
                n_beats += (len > KEY_BYTES) ? KEY_BYTES : len;
            end
            else
            begin
                len = $urandom_range(1, 30);
                for (int k = 0; k < len; k++)
                    queue_beat(1'b1, byte_t'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)),
                               k == 0 && $urandom_range(0, 19) == 0);
                n_beats += len;
            end
        end

        wait (rst_n);
        while (beats_to_send.size() != 0 || item_valid || out_bytes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (mismatch_cnt == 0 && out_bytes_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #1_500_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
